// ===== hdl/spd_pkg.sv =====
`default_nettype none
package spd_pkg;

  // stream layout
  localparam int STREAM_COUNT = 16;
  localparam int SID_W        = $clog2(STREAM_COUNT);
  localparam int BUF_BYTES    = 65536;
  localparam int FILL_W       = 17;
  localparam int OFFSET_W     = 16;
  localparam int LEN_W        = 15;

  // header format
  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam int         EOF_BIT      = 7;
  localparam logic [1:0] HDR_LAST_IDX = 2'd3;

  // register map
  localparam int         PADDR_W           = 3;
  localparam logic [0:0] REG_STREAM_ENABLE = 1'b0;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_SYNC_ERR  = 2'd2,
    KIND_NOT_REG   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [SID_W-1:0]     stream_num;
    logic [OFFSET_W-1:0]  offset;
    logic [7:0]           payload;
    logic                 packet_last;
    logic                 frame_end;
    logic [FILL_W-1:0]    frame_length;
    logic                 overflow;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/spd_regs.sv =====
`default_nettype none
module spd_regs
  import spd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [PADDR_W-1:0]       paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready,
  output logic      [STREAM_COUNT-1:0]  stream_enable
);

  logic wr_en;

  // write strobe on the access phase
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_enable <= '0;
    end else if (wr_en && paddr[2] == REG_STREAM_ENABLE) begin
      stream_enable <= pwdata[STREAM_COUNT-1:0];
    end
  end

  // read back, zero beyond the map
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_STREAM_ENABLE) begin
      prdata[STREAM_COUNT-1:0] = stream_enable;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/spd_core.sv =====
`default_nettype none
module spd_core
  import spd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     take,
  input  wire logic                     action,
  input  wire logic [7:0]               data_byte,
  input  wire logic [SID_W-1:0]         target_stream,
  input  wire logic [STREAM_COUNT-1:0]  stream_enable,
  output logic                          res_valid,
  output result_t                       res
);

  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BUF_BYTES);

  // header and payload tracking
  logic [1:0]        header_count, header_count_next;
  logic [12:0]       header_hold, header_hold_next;
  logic              in_payload, in_payload_next;
  logic              discard_payload, discard_payload_next;
  logic [SID_W-1:0]  current_stream, current_stream_next;
  logic              end_flag, end_flag_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [FILL_W-1:0] stream_fill [STREAM_COUNT];

  logic              fill_we;
  logic [SID_W-1:0]  fill_waddr;
  logic [FILL_W-1:0] fill_wdata;

  logic [SID_W-1:0]  hdr_sid;
  logic [7:0]        hdr_b2;
  logic [LEN_W-1:0]  hdr_len;
  logic [SID_W-1:0]  rd_sid;
  logic [FILL_W-1:0] fill_rd;
  logic [LEN_W-1:0]  bl_dec;
  logic              pkt_last;

  assign hdr_sid = header_hold[8 +: SID_W];
  assign hdr_b2  = header_hold[7:0];
  assign hdr_len = {hdr_b2[6:0], data_byte};
  assign rd_sid  = in_payload ? current_stream : hdr_sid;
  assign fill_rd = stream_fill[rd_sid];
  assign bl_dec  = bytes_left - LEN_W'(1);
  assign pkt_last = (bl_dec == '0);

  // per-item decode
  always_comb begin
    header_count_next    = header_count;
    header_hold_next     = header_hold;
    in_payload_next      = in_payload;
    discard_payload_next = discard_payload;
    current_stream_next  = current_stream;
    end_flag_next        = end_flag;
    bytes_left_next      = bytes_left;
    fill_we              = 1'b0;
    fill_waddr           = target_stream;
    fill_wdata           = '0;
    res_valid            = 1'b0;
    res                  = '0;
    if (take) begin
      if (action) begin
        // clear fill of an enabled stream
        fill_we = stream_enable[target_stream];
      end else if (in_payload) begin
        bytes_left_next = bl_dec;
        if (pkt_last) begin
          in_payload_next      = 1'b0;
          discard_payload_next = 1'b0;
        end
        if (!discard_payload) begin
          res_valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.stream_num   = current_stream;
          res.payload      = data_byte;
          res.packet_last  = pkt_last;
          res.frame_end    = pkt_last && end_flag;
          if (fill_rd < FILL_MAX) begin
            fill_we          = 1'b1;
            fill_waddr       = current_stream;
            fill_wdata       = fill_rd + FILL_W'(1);
            res.offset       = fill_rd[OFFSET_W-1:0];
            res.frame_length = fill_rd + FILL_W'(1);
          end else begin
            res.frame_length = fill_rd;
            res.overflow     = 1'b1;
          end
        end
      end else begin
        header_count_next = header_count + 2'd1;
        case (header_count)
          2'd0: header_hold_next = {(data_byte != SYNC_BYTE), 12'd0};
          2'd1: header_hold_next = {header_hold[12], data_byte[SID_W-1:0], 8'd0};
          2'd2: header_hold_next = {header_hold[12:8], data_byte};
          default: begin
            // last header byte: decide the packet
            res_valid         = 1'b1;
            res.packet_last   = 1'b1;
            if (header_hold[12]) begin
              res.kind = KIND_SYNC_ERR;
            end else if (!stream_enable[hdr_sid]) begin
              res.kind       = KIND_NOT_REG;
              res.stream_num = hdr_sid;
              if (hdr_len != '0) begin
                in_payload_next      = 1'b1;
                discard_payload_next = 1'b1;
                bytes_left_next      = hdr_len;
              end
            end else if (hdr_len == '0) begin
              res.kind         = KIND_EMPTY;
              res.stream_num   = hdr_sid;
              res.offset       = fill_rd[OFFSET_W-1:0];
              res.frame_length = fill_rd;
              res.frame_end    = hdr_b2[EOF_BIT];
            end else begin
              res_valid            = 1'b0;
              in_payload_next      = 1'b1;
              discard_payload_next = 1'b0;
              current_stream_next  = hdr_sid;
              end_flag_next        = hdr_b2[EOF_BIT];
              bytes_left_next      = hdr_len;
            end
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count    <= '0;
      header_hold     <= '0;
      in_payload      <= 1'b0;
      discard_payload <= 1'b0;
      current_stream  <= '0;
      end_flag        <= 1'b0;
      bytes_left      <= '0;
      for (int i = 0; i < STREAM_COUNT; i++) begin
        stream_fill[i] <= '0;
      end
    end else begin
      header_count    <= header_count_next;
      header_hold     <= header_hold_next;
      in_payload      <= in_payload_next;
      discard_payload <= discard_payload_next;
      current_stream  <= current_stream_next;
      end_flag        <= end_flag_next;
      bytes_left      <= bytes_left_next;
      if (fill_we) begin
        stream_fill[fill_waddr] <= fill_wdata;
      end
    end
  end

  // checks
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.overflow |-> fill_rd == FILL_MAX && res.kind == KIND_PAYLOAD)
    else $error("overflow flagged on a stream that is not full");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    take && action && stream_enable[target_stream]
      |=> stream_fill[$past(target_stream)] == '0)
    else $error("fill not cleared by reset action");

  a_no_res_action: assert property (@(posedge clk) disable iff (rst)
    take && action |-> !res_valid && header_count_next == header_count)
    else $error("reset action disturbed header tracking");

  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    take && !action && in_payload && discard_payload |-> !res_valid)
    else $error("result from a discarded payload byte");

endmodule
`default_nettype wire

// ===== hdl/spd_out_queue.sv =====
`default_nettype none
module spd_out_queue
  import spd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  result_t      push_data,
  output logic         has_room,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      head
);

  logic [1:0] count, count_next;
  result_t    entry0, entry1;
  logic       pop;
  logic [1:0] wr_pos;

  assign out_valid = (count != 2'd0);
  assign has_room  = (count != 2'd2);
  assign head      = entry0;
  assign pop       = out_valid && out_ready;
  assign wr_pos    = count - {1'b0, pop};
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // two-entry skid storage, head in entry0
  always_ff @(posedge clk) begin
    if (pop && count == 2'd2) begin
      entry0 <= entry1;
    end
    if (push && wr_pos == 2'd0) begin
      entry0 <= push_data;
    end
    if (push && wr_pos == 2'd1) begin
      entry1 <= push_data;
    end
  end

  // checks
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !pop |-> !push)
    else $error("item pushed into a full output queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output queue count out of range");

  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry0))
    else $error("waiting result changed");

endmodule
`default_nettype wire

// ===== hdl/stream_packet_deframer_top.sv =====
`default_nettype none
// Packet deframer for a byte link. One byte (or fill reset action) is taken per
// clock cycle: the header and payload decode is a single pass of logic between
// the accept edge and a two-entry output queue, so items flow back to back and
// in_ready drops only while both queue entries hold results not yet taken.
// Reset actions, discarded payload bytes and header bytes but the last give no
// result, nor does a last byte opening an enabled payload. Per-stream fill
// counts sit in flip-flops cleared at reset, so the block is ready in the cycle
// after reset with no clearing pass. stream_enable lies at APB byte address 0.
module stream_packet_deframer_top
  import spd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 action,
  input  wire logic [7:0]           data_byte,
  input  wire logic [SID_W-1:0]     target_stream,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [1:0]           kind,
  output logic      [SID_W-1:0]     stream_num,
  output logic      [OFFSET_W-1:0]  offset,
  output logic      [7:0]           payload,
  output logic                      packet_last,
  output logic                      frame_end,
  output logic      [FILL_W-1:0]    frame_length,
  output logic                      overflow,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);

  logic [STREAM_COUNT-1:0] stream_enable;
  logic                    take;
  logic                    res_valid;
  result_t                 res;
  result_t                 head;
  logic                    has_room;

  assign in_ready = has_room;
  assign take     = in_valid && in_ready;

  spd_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .stream_enable (stream_enable)
  );

  spd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .action        (action),
    .data_byte     (data_byte),
    .target_stream (target_stream),
    .stream_enable (stream_enable),
    .res_valid     (res_valid),
    .res           (res)
  );

  spd_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // result fields
  assign kind         = head.kind;
  assign stream_num   = head.stream_num;
  assign offset       = head.offset;
  assign payload      = head.payload;
  assign packet_last  = head.packet_last;
  assign frame_end    = head.frame_end;
  assign frame_length = head.frame_length;
  assign overflow     = head.overflow;

endmodule
`default_nettype wire

// ===== bench/deframer_tb_pkg.sv =====
package deframer_tb_pkg;
  import spd_pkg::*;

  // action codes of an input item
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // byte address of the stream enable register
  localparam logic [PADDR_W-1:0] ENABLE_ADDR = PADDR_W'(4 * int'(REG_STREAM_ENABLE));

endpackage

// ===== bench/deframer_monitor.sv =====
module deframer_monitor
  import spd_pkg::*;
  import deframer_tb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_ready,
  input  wire logic                action,
  input  wire logic [7:0]          data_byte,
  input  wire logic [SID_W-1:0]    target_stream,
  input  wire logic                out_valid,
  input  wire logic                out_ready,
  input  wire logic [1:0]          kind,
  input  wire logic [SID_W-1:0]    stream_num,
  input  wire logic [OFFSET_W-1:0] offset,
  input  wire logic [7:0]          payload,
  input  wire logic                packet_last,
  input  wire logic                frame_end,
  input  wire logic [FILL_W-1:0]   frame_length,
  input  wire logic                overflow,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [31:0]         pwdata,
  input  wire logic                pready,
  output int                       fault_count,
  output int                       pending_count,
  output logic                     at_boundary
);

  // shadow of the block's register and parser state
  logic [STREAM_COUNT-1:0] enable_mask;
  logic [1:0]              hdr_pos;
  logic                    hdr_bad;
  logic [SID_W-1:0]        hdr_sid;
  logic [7:0]              hdr_len_hi;
  logic                    in_body;
  logic                    skip_body;
  logic                    body_eof;
  logic [SID_W-1:0]        body_sid;
  logic [LEN_W-1:0]        body_left;
  logic [FILL_W-1:0]       fill [STREAM_COUNT];

  // results still owed by the block, oldest first
  result_t deframed_q [$];

  function automatic result_t make_result(input kind_t k, input logic [SID_W-1:0] sid,
                                          input logic [OFFSET_W-1:0] offs,
                                          input logic [7:0] pay, input logic last,
                                          input logic fend, input logic [FILL_W-1:0] flen,
                                          input logic ovf);
    result_t r;
    r.kind         = k;
    r.stream_num   = sid;
    r.offset       = offs;
    r.payload      = pay;
    r.packet_last  = last;
    r.frame_end    = fend;
    r.frame_length = flen;
    r.overflow     = ovf;
    return r;
  endfunction

  // advance the parser by one accepted item and queue what it yields
  task automatic deframe_item(input logic act, input logic [7:0] b,
                              input logic [SID_W-1:0] tgt);
    logic              last;
    logic [FILL_W-1:0] f;
    logic [LEN_W-1:0]  len;
    if (act == ACT_CLEAR) begin
      if (enable_mask[tgt]) fill[tgt] = '0;
    end else if (in_body) begin
      body_left = body_left - 1'b1;
      last = (body_left == '0);
      if (last) in_body = 1'b0;
      if (skip_body) begin
        if (last) skip_body = 1'b0;
      end else begin
        f = fill[body_sid];
        if (f < FILL_W'(BUF_BYTES)) begin
          fill[body_sid] = f + 1'b1;
          deframed_q.push_back(make_result(KIND_PAYLOAD, body_sid, f[OFFSET_W-1:0], b,
                                           last, last & body_eof, f + 1'b1, 1'b0));
        end else begin
          // buffer full: byte dropped, still counted in the packet
          deframed_q.push_back(make_result(KIND_PAYLOAD, body_sid, '0, b,
                                           last, last & body_eof, f, 1'b1));
        end
      end
    end else if (hdr_pos != HDR_LAST_IDX) begin
      case (hdr_pos)
        2'd0: hdr_bad = (b != SYNC_BYTE);
        2'd1: hdr_sid = b[SID_W-1:0];
        default: hdr_len_hi = b;
      endcase
      hdr_pos = hdr_pos + 1'b1;
    end else begin
      hdr_pos = '0;
      len = {hdr_len_hi[6:0], b};
      if (hdr_bad) begin
        deframed_q.push_back(make_result(KIND_SYNC_ERR, '0, '0, '0, 1'b1, 1'b0, '0, 1'b0));
      end else if (!enable_mask[hdr_sid]) begin
        // unregistered stream: its payload is swallowed
        if (len != '0) begin
          in_body   = 1'b1;
          skip_body = 1'b1;
          body_left = len;
        end
        deframed_q.push_back(make_result(KIND_NOT_REG, hdr_sid, '0, '0, 1'b1, 1'b0, '0, 1'b0));
      end else if (len == '0) begin
        f = fill[hdr_sid];
        deframed_q.push_back(make_result(KIND_EMPTY, hdr_sid, f[OFFSET_W-1:0], '0, 1'b1,
                                         hdr_len_hi[EOF_BIT], f, 1'b0));
      end else begin
        in_body   = 1'b1;
        skip_body = 1'b0;
        body_sid  = hdr_sid;
        body_eof  = hdr_len_hi[EOF_BIT];
        body_left = len;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fault_count++;
    end
  endtask

  // sample both channels and the register port at each rising edge
  always @(posedge clk) begin : watch
    result_t want;
    int i;
    if (rst) begin
      enable_mask = '0;
      hdr_pos     = '0;
      hdr_bad     = 1'b0;
      hdr_sid     = '0;
      hdr_len_hi  = '0;
      in_body     = 1'b0;
      skip_body   = 1'b0;
      body_eof    = 1'b0;
      body_sid    = '0;
      body_left   = '0;
      for (i = 0; i < STREAM_COUNT; i++) fill[i] = '0;
      deframed_q.delete();
      fault_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ENABLE_ADDR)
        enable_mask = pwdata[STREAM_COUNT-1:0];
      if (in_valid && in_ready) deframe_item(action, data_byte, target_stream);
      if (out_valid && out_ready) begin
        if (deframed_q.size() == 0) begin
          $display("%0t: unexpected item, expected none actual kind %0d stream %0d",
                   $time, kind, stream_num);
          fault_count++;
        end else begin
          want = deframed_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("stream_num", 32'(want.stream_num), 32'(stream_num));
          check_field("offset", 32'(want.offset), 32'(offset));
          check_field("payload", 32'(want.payload), 32'(payload));
          check_field("packet_last", 32'(want.packet_last), 32'(packet_last));
          check_field("frame_end", 32'(want.frame_end), 32'(frame_end));
          check_field("frame_length", 32'(want.frame_length), 32'(frame_length));
          check_field("overflow", 32'(want.overflow), 32'(overflow));
        end
      end
    end
    pending_count = deframed_q.size();
    at_boundary   = (hdr_pos == '0) && !in_body;
  end

endmodule

// ===== bench/stream_packet_deframer_top_test.sv =====
module stream_packet_deframer_top_test;
  import spd_pkg::*;
  import deframer_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 750;
  localparam int PHASES        = 6;
  localparam int SETTLE_CYCLES = 8;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                action;
  logic [7:0]          data_byte;
  logic [SID_W-1:0]    target_stream;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          kind;
  logic [SID_W-1:0]    stream_num;
  logic [OFFSET_W-1:0] offset;
  logic [7:0]          payload;
  logic                packet_last;
  logic                frame_end;
  logic [FILL_W-1:0]   frame_length;
  logic                overflow;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int   fault_count;
  int   pending_count;
  logic at_boundary;
  int   cycle_count = 0;
  int   items_sent;
  logic quiet;

  stream_packet_deframer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .data_byte(data_byte), .target_stream(target_stream),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .stream_num(stream_num), .offset(offset), .payload(payload),
    .packet_last(packet_last), .frame_end(frame_end),
    .frame_length(frame_length), .overflow(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  deframer_monitor monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .data_byte(data_byte), .target_stream(target_stream),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .stream_num(stream_num), .offset(offset), .payload(payload),
    .packet_last(packet_last), .frame_end(frame_end),
    .frame_length(frame_length), .overflow(overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fault_count(fault_count), .pending_count(pending_count),
    .at_boundary(at_boundary)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[stream_packet_deframer_top] ERROR");
      $finish;
    end
  end

  // result side: random stall bursts, always ready once quiet
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  // one item, with an occasional idle burst in front; starts and ends at a falling edge
  task automatic send_item(input logic act, input logic [7:0] b,
                           input logic [SID_W-1:0] tgt);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    data_byte     <= b;
    target_stream <= tgt;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_header(input logic [7:0] b0, input logic [7:0] b1,
                             input logic [7:0] b2, input logic [7:0] b3);
    send_item(ACT_BYTE, b0, SID_W'($urandom));
    send_item(ACT_BYTE, b1, SID_W'($urandom));
    send_item(ACT_BYTE, b2, SID_W'($urandom));
    send_item(ACT_BYTE, b3, SID_W'($urandom));
  endtask

  // well-formed packet with random payload, fill clears optionally mixed in
  task automatic send_packet(input logic [SID_W-1:0] sid, input logic [3:0] junk,
                             input logic eof, input logic [LEN_W-1:0] len,
                             input logic mix_clears);
    int i;
    send_header(SYNC_BYTE, {junk, sid}, {eof, len[14:8]}, len[7:0]);
    for (i = 0; i < int'(len); i++) begin
      if (mix_clears && $urandom_range(0, 11) == 0)
        send_item(ACT_CLEAR, 8'($urandom), SID_W'($urandom));
      send_item(ACT_BYTE, 8'($urandom), SID_W'($urandom));
    end
  endtask

  // hold the sender until every owed result is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_enable(input logic [15:0] mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENABLE_ADDR;
    pwdata  <= {16'($urandom), mask};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one random stretch of traffic, mostly well-formed packets
  task automatic random_burst();
    int r;
    int n;
    logic [LEN_W-1:0] len;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 40))
                                        : LEN_W'($urandom_range(0, 6));
      send_packet(SID_W'($urandom), 4'($urandom), 1'($urandom), len, 1'b1);
    end else if (r < 82) begin
      send_item(ACT_CLEAR, 8'($urandom), SID_W'($urandom));
    end else if (r < 95) begin
      // bad sync header with random remaining bytes
      send_header(8'($urandom_range(0, 254)), 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      // stray bytes, then zeros until the parser is back at a header start
      repeat ($urandom_range(1, 3)) send_item(ACT_BYTE, 8'($urandom), SID_W'($urandom));
      n = 0;
      while (!at_boundary && n < 300) begin
        send_item(ACT_BYTE, 8'h00, SID_W'($urandom));
        n++;
      end
    end
  endtask

  initial begin
    int p;
    logic [15:0] mask;
    rst           = 1'b1;
    in_valid      = 1'b0;
    action        = ACT_BYTE;
    data_byte     = '0;
    target_stream = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    quiet         = 1'b0;
    items_sent    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // nothing registered: payload swallowed, bad sync, clear of a disabled stream
    write_enable(16'h0000);
    send_packet(SID_W'(3), 4'hA, 1'b0, LEN_W'(2), 1'b0);
    send_header(8'hFE, 8'hFF, 8'hFF, 8'hFF);
    send_item(ACT_CLEAR, 8'h00, SID_W'(15));
    drain();

    // all registered: empty packet, single byte with frame end, clear mid packet
    write_enable(16'hFFFF);
    send_header(SYNC_BYTE, 8'h00, 8'h00, 8'h00);
    send_packet(SID_W'(15), 4'hF, 1'b1, LEN_W'(1), 1'b0);
    send_header(SYNC_BYTE, 8'h05, 8'h00, 8'h03);
    send_item(ACT_BYTE, 8'h00, SID_W'(0));
    send_item(ACT_CLEAR, 8'hFF, SID_W'(5));
    send_item(ACT_BYTE, 8'h55, SID_W'(0));
    send_item(ACT_BYTE, 8'hAA, SID_W'(0));
    send_header(SYNC_BYTE, 8'h05, 8'h80, 8'h00);

    // fill carried across packets on one stream, then empty packets around a clear
    send_packet(SID_W'(9), 4'h0, 1'b0, LEN_W'(6), 1'b0);
    send_packet(SID_W'(9), 4'h0, 1'b1, LEN_W'(4), 1'b0);
    send_header(SYNC_BYTE, 8'h09, 8'h80, 8'h00);
    send_item(ACT_CLEAR, 8'h00, SID_W'(9));
    send_header(SYNC_BYTE, 8'h09, 8'h00, 8'h00);

    // random phases, each under its own enable setting
    items_sent = 0;
    for (p = 0; p < PHASES; p++) begin
      drain();
      if (p == 1) mask = 16'h0000;
      else if (p == 2 || p == PHASES - 1) mask = 16'hFFFF;
      else mask = 16'($urandom);
      write_enable(mask);
      if (p == PHASES - 1) quiet = 1'b1;
      while (items_sent < (p + 1) * RANDOM_ITEMS / PHASES) random_burst();
    end
    drain();

    if (fault_count == 0) begin
      $display("[stream_packet_deframer_top] OK");
    end else begin
      $display("[stream_packet_deframer_top] ERROR");
    end
    $finish;
  end

endmodule
